>>> design/gslc_pkg.sv
// ---------------------------------------------------------------------------
// gslc_pkg: shared constants and types for the grid sync launch checker
// Widths, reset values, mode codes and controller/datapath command structs.
// ---------------------------------------------------------------------------
package gslc_pkg;

  localparam int FreqLowLimitDef  = 56320;
  localparam int FreqHighLimitDef = 66560;
  localparam int MaxPowerDef      = 100000;

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_ACT   = 2'd1;
  localparam logic [1:0] MODE_DEACT = 2'd2;

  localparam logic [2:0] REG_UPDATE_DELAY  = 3'd0;
  localparam logic [2:0] REG_RESISTIVE     = 3'd1;
  localparam logic [2:0] REG_MAX_FSPREAD   = 3'd2;
  localparam logic [2:0] REG_MAX_PSPREAD   = 3'd3;
  localparam logic [2:0] REG_MIN_SYNC_MAG  = 3'd4;
  localparam logic [2:0] REG_PHASE_LEAD    = 3'd5;
  localparam logic [2:0] REG_LAUNCH_LOCKED = 3'd6;
  localparam logic [2:0] REG_BASE_FREQ     = 3'd7;

  localparam logic [16:0] FREQ_RESET   = 17'd61440;
  localparam logic [16:0] CLAMP_LOW_F  = 17'd59392;
  localparam logic [16:0] CLAMP_HIGH_F = 17'd63488;
  localparam logic [20:0] TICK_MAX     = 21'h1FFFFF;
  localparam logic [15:0] AMP_ONE      = 16'd32768;
  localparam int          FULL_TURN    = 46080;
  localparam int          OSC_LEAD     = 806;
  localparam logic [13:0] ISO_MAG      = 14'd480;
  localparam logic [13:0] SYNC_HEAD    = 14'd160;

  // datapath commands from the controller
  typedef struct packed {
    logic load_in;    // capture input word and start work
    logic div_start;  // start a divide
    logic div_sel;    // 0: ticks, 1: amplitude
  } gslc_cmd_t;

  typedef struct packed {
    logic div_busy;
  } gslc_sts_t;

endpackage

>>> design/gslc_div.sv
// ---------------------------------------------------------------------------
// gslc_div: radix-2 restoring divider
// One quotient bit per cycle; 42-bit dividend, 24-bit divisor.
// ---------------------------------------------------------------------------
module gslc_div import gslc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [41:0] dividend,
  input  logic [23:0] divisor,
  output logic        busy,
  output logic [41:0] quot
);
  logic [41:0] q_r, q_nxt;
  logic [24:0] rem_r, rem_nxt;
  logic [23:0] d_r, d_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [24:0] trial;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; d_nxt = d_r; cnt_nxt = cnt_r; busy_nxt = busy_r;
    trial = {rem_r[23:0], q_r[41]};
    if (start) begin
      q_nxt = dividend; rem_nxt = '0; d_nxt = divisor;
      cnt_nxt = 6'd42; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        rem_nxt = trial - {1'b0, d_r};
        q_nxt   = {q_r[40:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[40:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; d_r <= d_nxt;
  end

  assign busy = busy_r;
  assign quot = q_r;
endmodule

>>> design/gslc_datapath.sv
// ---------------------------------------------------------------------------
// gslc_datapath: tracker state, window min/max, decision and result word
// Captures one input word, runs two divides and forms the result fields.
// ---------------------------------------------------------------------------
module gslc_datapath import gslc_pkg::*; #(
  parameter int FreqLowLimit  = FreqLowLimitDef,
  parameter int FreqHighLimit = FreqHighLimitDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  gslc_cmd_t          cmd,
  output gslc_sts_t          sts,
  input  logic [1:0]         in_mode,
  input  logic signed [15:0] in_grid_phase,
  input  logic [16:0]        in_grid_frequency,
  input  logic [13:0]        in_grid_magnitude,
  input  logic [15:0]        in_oscillator_phase,
  input  logic [13:0]        in_dc_link_voltage,
  input  logic [13:0]        in_dc_setpoint,
  input  logic [15:0]        update_delay,
  input  logic               resistive_load,
  input  logic [16:0]        max_freq_spread,
  input  logic [15:0]        max_phase_spread,
  input  logic [13:0]        min_sync_magnitude,
  input  logic signed [15:0] phase_lead,
  input  logic               launch_locked,
  input  logic [16:0]        base_frequency,
  output logic               res_active,
  output logic               res_launch,
  output logic               res_damping_write,
  output logic               res_drive_valid,
  output logic [16:0]        res_output_frequency,
  output logic [20:0]        res_pwm_phase_ticks,
  output logic [15:0]        res_start_amplitude
);
  // state
  logic               running_r;
  logic [15:0]        wcnt_r;
  logic signed [16:0] plo_r, phi_r;
  logic [16:0]        flo_r, fhi_r, trk_r;
  logic               lflag_r;
  // per-item operands held for the divides
  logic [16:0] tf_r;      // divisor frequency
  logic [16:0] sphase_r;  // set phase (1..78930 when positive)
  logic        spos_r;
  logic [14:0] anum_r;
  logic [13:0] aden_r;
  logic [16:0] ofreq_r;
  logic        valid_r, damp_r, need_tick_r;

  logic [31:0] osc_prod;
  logic signed [18:0] s_sum, s1, s2;
  logic signed [16:0] gp17, pd;
  logic [16:0] ps, fs, cf;
  logic sync_ok, iso_ok, dec, ld;

  assign gp17 = {in_grid_phase[15], in_grid_phase};
  assign osc_prod = in_oscillator_phase * 32'd58671 + 32'd32768;
  always_comb begin
    s_sum = 19'(gp17) + 19'(osc_prod[31:16]) + 19'(OSC_LEAD) + 19'(phase_lead);
    s1 = (s_sum < 0) ? s_sum + 19'(FULL_TURN) : s_sum;
    s2 = (s1 > 19'(FULL_TURN)) ? s1 - 19'(FULL_TURN) : s1;
    pd = phi_r - plo_r;
    ps = pd[16] ? 17'(-pd) : 17'(pd);
    fs = (fhi_r >= flo_r) ? fhi_r - flo_r : flo_r - fhi_r;
    cf = (trk_r < CLAMP_LOW_F) ? CLAMP_LOW_F : (trk_r > CLAMP_HIGH_F) ? CLAMP_HIGH_F : trk_r;
    dec = (wcnt_r > update_delay) || resistive_load;
    sync_ok = (fs < max_freq_spread) && (ps < 17'(max_phase_spread)) &&
              (in_grid_magnitude > min_sync_magnitude) && !resistive_load &&
              (trk_r > 17'(FreqLowLimit)) && (trk_r < 17'(FreqHighLimit));
    iso_ok = (in_grid_magnitude < ISO_MAG) || resistive_load;
  end
  assign ld = cmd.load_in;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0; wcnt_r <= '0; plo_r <= '0; phi_r <= '0;
      flo_r <= '0; fhi_r <= '0; trk_r <= FREQ_RESET; lflag_r <= 1'b0;
      valid_r <= 1'b0; damp_r <= 1'b0; need_tick_r <= 1'b0;
    end else if (ld) begin
      valid_r <= 1'b0; damp_r <= 1'b0; need_tick_r <= 1'b0;
      case (in_mode)
        MODE_ACT: begin
          running_r <= 1'b1; wcnt_r <= '0; plo_r <= gp17; phi_r <= gp17;
          flo_r <= in_grid_frequency; fhi_r <= in_grid_frequency; trk_r <= FREQ_RESET;
        end
        MODE_DEACT: begin
          running_r <= 1'b0; wcnt_r <= '0; plo_r <= '0; phi_r <= '0;
          flo_r <= '0; fhi_r <= '0; trk_r <= FREQ_RESET; lflag_r <= 1'b0;
        end
        MODE_TICK: begin
          if (running_r) begin
            if (dec) begin
              wcnt_r <= '0;
              if (sync_ok || iso_ok) begin
                valid_r <= 1'b1;
                need_tick_r <= sync_ok;
                if (!launch_locked) begin
                  damp_r <= 1'b1; lflag_r <= 1'b1; running_r <= 1'b0;
                end
              end else begin
                plo_r <= gp17; phi_r <= gp17;
                flo_r <= in_grid_frequency; fhi_r <= in_grid_frequency;
                trk_r <= in_grid_frequency;
              end
            end else begin
              wcnt_r <= wcnt_r + 16'd1;
              if (plo_r > gp17) plo_r <= gp17;
              if (phi_r < gp17) phi_r <= gp17;
              if (flo_r > in_grid_frequency) flo_r <= in_grid_frequency;
              if (fhi_r < in_grid_frequency) fhi_r <= in_grid_frequency;
              valid_r <= 1'b1; need_tick_r <= 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
    if (ld) begin
      sphase_r <= s2[16:0];
      spos_r   <= (s2 > 0);
      if (!dec) begin
        ofreq_r <= cf; tf_r <= cf;
        anum_r <= {1'b0, in_grid_magnitude}; aden_r <= in_dc_setpoint;
      end else if (sync_ok) begin
        ofreq_r <= trk_r; tf_r <= trk_r;
        anum_r <= 15'(in_grid_magnitude) + 15'(SYNC_HEAD); aden_r <= in_dc_link_voltage;
      end else begin
        ofreq_r <= base_frequency; tf_r <= trk_r;
        anum_r <= resistive_load ? 15'd0 : {1'b0, in_grid_magnitude};
        aden_r <= in_dc_setpoint;
      end
    end
  end

  // divides: ticks = 50e6*s / (45*f); amp = num*65536 / den
  // set phase can reach about 79000, so the tick dividend needs 42 bits
  logic [41:0] dvd, quot;
  logic [23:0] dvs;
  logic        dbusy;
  logic [41:0] tq_r, aq_r;
  logic        busy_d_r;
  logic        sel_r;

  assign dvd = cmd.div_sel ? {11'd0, anum_r, 16'd0} : 42'(sphase_r) * 42'd50000000;
  assign dvs = cmd.div_sel ? {10'd0, aden_r} : 24'(tf_r) * 24'd45;

  gslc_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .dividend(dvd), .divisor(dvs), .busy(dbusy), .quot(quot)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) busy_d_r <= 1'b0;
    else        busy_d_r <= dbusy;
    if (cmd.div_start) sel_r <= cmd.div_sel;
    if (busy_d_r && !dbusy) begin
      if (sel_r) aq_r <= quot;
      else       tq_r <= quot;
    end
  end
  assign sts.div_busy = dbusy || (busy_d_r && !dbusy) || cmd.div_start;

  always_comb begin
    res_active = running_r;
    res_launch = lflag_r;
    res_damping_write = damp_r;
    res_drive_valid = valid_r;
    res_output_frequency = valid_r ? ofreq_r : 17'd0;
    if (!valid_r || !need_tick_r || !spos_r) res_pwm_phase_ticks = '0;
    else if (tf_r == 17'd0 || tq_r > 42'(TICK_MAX)) res_pwm_phase_ticks = TICK_MAX;
    else res_pwm_phase_ticks = tq_r[20:0];
    if (!valid_r) res_start_amplitude = '0;
    else if (aden_r <= 14'd16 || aq_r > 42'(AMP_ONE)) res_start_amplitude = AMP_ONE;
    else res_start_amplitude = aq_r[15:0];
  end
endmodule

>>> design/gslc_ctrl.sv
// ---------------------------------------------------------------------------
// gslc_ctrl: sequencer for one input word
// Accept, run the tick divide then the amplitude divide, hold the result.
// ---------------------------------------------------------------------------
module gslc_ctrl import gslc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output gslc_cmd_t cmd,
  input  gslc_sts_t sts
);
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV0  = 3'd1;
  localparam logic [2:0] ST_WAIT0 = 3'd2;
  localparam logic [2:0] ST_DIV1  = 3'd3;
  localparam logic [2:0] ST_WAIT1 = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  logic [2:0] st_r, st_nxt;

  always_comb begin
    st_nxt = st_r;
    cmd = '0;
    case (st_r)
      ST_IDLE:  if (in_valid) begin cmd.load_in = 1'b1; st_nxt = ST_DIV0; end
      ST_DIV0:  begin cmd.div_start = 1'b1; st_nxt = ST_WAIT0; end
      ST_WAIT0: if (!sts.div_busy) st_nxt = ST_DIV1;
      ST_DIV1:  begin cmd.div_start = 1'b1; cmd.div_sel = 1'b1; st_nxt = ST_WAIT1; end
      ST_WAIT1: begin cmd.div_sel = 1'b1; if (!sts.div_busy) st_nxt = ST_OUT; end
      ST_OUT:   if (!out_stall) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_IDLE;
    else        st_r <= st_nxt;
  end

  assign in_stall  = (st_r != ST_IDLE);
  assign out_valid = (st_r == ST_OUT);
endmodule

>>> design/grid_sync_launch_checker.sv
// ---------------------------------------------------------------------------
// grid_sync_launch_checker: grid synchroniser and launch decision
// Tracks grid phase/frequency spread and decides when the inverter launches.
// ---------------------------------------------------------------------------
// One input word is taken at a time and yields exactly one result word. Both
// the PWM phase (ticks) and the start amplitude come out of one shared
// radix-2 divider that produces a quotient bit per cycle over 42 bits, run
// twice in turn (start, 42 steps, then capture and hand-over, for each
// divide). in_stall stays high until the result word has been taken, so the
// next word is taken only once ST_OUT has returned to ST_IDLE. Configuration
// registers sit at byte address 4*i and are written via the cfg_ APB port.
module grid_sync_launch_checker import gslc_pkg::*; #(
  parameter int FreqLowLimit  = FreqLowLimitDef,
  parameter int FreqHighLimit = FreqHighLimitDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_mode,
  input  logic signed [15:0] in_grid_phase,
  input  logic [16:0]        in_grid_frequency,
  input  logic [13:0]        in_grid_magnitude,
  input  logic [15:0]        in_oscillator_phase,
  input  logic [13:0]        in_dc_link_voltage,
  input  logic [13:0]        in_dc_setpoint,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_active,
  output logic               out_launch,
  output logic               out_damping_write,
  output logic               out_drive_valid,
  output logic [16:0]        out_output_frequency,
  output logic [20:0]        out_pwm_phase_ticks,
  output logic [15:0]        out_start_amplitude,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [4:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  // configuration registers
  logic [15:0]        update_delay_r;
  logic               resistive_r;
  logic [16:0]        max_fs_r;
  logic [15:0]        max_ps_r;
  logic [13:0]        min_mag_r;
  logic signed [15:0] lead_r;
  logic               locked_r;
  logic [16:0]        base_f_r;
  logic [2:0]         ridx;
  logic               cfg_wr;

  assign cfg_pready = 1'b1;
  assign ridx   = cfg_paddr[4:2];
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      update_delay_r <= 16'd100; resistive_r <= 1'b0; max_fs_r <= 17'd512;
      max_ps_r <= 16'd640; min_mag_r <= 14'd1600; lead_r <= '0;
      locked_r <= 1'b0; base_f_r <= FREQ_RESET;
    end else if (cfg_wr) begin
      case (ridx)
        REG_UPDATE_DELAY:  update_delay_r <= cfg_pwdata[15:0];
        REG_RESISTIVE:     resistive_r    <= cfg_pwdata[0];
        REG_MAX_FSPREAD:   max_fs_r       <= cfg_pwdata[16:0];
        REG_MAX_PSPREAD:   max_ps_r       <= cfg_pwdata[15:0];
        REG_MIN_SYNC_MAG:  min_mag_r      <= cfg_pwdata[13:0];
        REG_PHASE_LEAD:    lead_r         <= cfg_pwdata[15:0];
        REG_LAUNCH_LOCKED: locked_r       <= cfg_pwdata[0];
        REG_BASE_FREQ:     base_f_r       <= cfg_pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_UPDATE_DELAY:  cfg_prdata = 32'(update_delay_r);
      REG_RESISTIVE:     cfg_prdata = 32'(resistive_r);
      REG_MAX_FSPREAD:   cfg_prdata = 32'(max_fs_r);
      REG_MAX_PSPREAD:   cfg_prdata = 32'(max_ps_r);
      REG_MIN_SYNC_MAG:  cfg_prdata = 32'(min_mag_r);
      REG_PHASE_LEAD:    cfg_prdata = {{16{lead_r[15]}}, lead_r};
      REG_LAUNCH_LOCKED: cfg_prdata = 32'(locked_r);
      REG_BASE_FREQ:     cfg_prdata = 32'(base_f_r);
      default:           cfg_prdata = '0;
    endcase
  end

  gslc_cmd_t cmd;
  gslc_sts_t sts;

  gslc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts)
  );

  gslc_datapath #(.FreqLowLimit(FreqLowLimit), .FreqHighLimit(FreqHighLimit)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_mode(in_mode), .in_grid_phase(in_grid_phase),
    .in_grid_frequency(in_grid_frequency), .in_grid_magnitude(in_grid_magnitude),
    .in_oscillator_phase(in_oscillator_phase), .in_dc_link_voltage(in_dc_link_voltage),
    .in_dc_setpoint(in_dc_setpoint),
    .update_delay(update_delay_r), .resistive_load(resistive_r),
    .max_freq_spread(max_fs_r), .max_phase_spread(max_ps_r),
    .min_sync_magnitude(min_mag_r), .phase_lead(lead_r),
    .launch_locked(locked_r), .base_frequency(base_f_r),
    .res_active(out_active), .res_launch(out_launch),
    .res_damping_write(out_damping_write), .res_drive_valid(out_drive_valid),
    .res_output_frequency(out_output_frequency),
    .res_pwm_phase_ticks(out_pwm_phase_ticks),
    .res_start_amplitude(out_start_amplitude)
  );

  // a damping load always comes with a launch and a drop out of active
  a_damp_launch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_damping_write |-> out_launch && !out_active && out_drive_valid)
    else $error("damping write without launch");
  // no new word while a result is pending
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input open with result pending");
  // idle results carry zero drive fields
  a_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_drive_valid |-> out_output_frequency == 17'd0 &&
    out_start_amplitude == 16'd0) else $error("drive fields not cleared");
endmodule
